/* src/sfla_pkg.sv */
// ----------------------------------------------------------------------------
// sfla_pkg: shared definitions of the segregated free-list allocator
// Constants, codes, and the command and status records between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sfla_pkg;

   localparam int ARENA_BYTES    = 65536;
   localparam int GRANULE        = 8;
   localparam int GRAN_SHIFT     = 3;
   localparam int SMALL_LIMIT    = 128;
   localparam int LIST_COUNT     = 16;
   localparam int LIST_W         = 4;
   localparam int STORE_DEPTH    = ARENA_BYTES / GRANULE;
   localparam int GIDX_W         = 13;
   localparam int POOL_W         = 17;
   localparam int ARENA_CAPACITY = ARENA_BYTES - GRANULE;
   localparam int REFILL_RESET   = 20;
   localparam int CNT_W          = 7;
   localparam int SIZE_W         = 16;
   localparam int N_W            = 8;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_REALLOC = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERSIZE  = 2'd1,
      STATUS_NO_MEMORY = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_FREE_OLD,
      CMD_FREE_NEW,
      CMD_SET_BIG,
      CMD_POP_READ,
      CMD_POP_DONE,
      CMD_REFILL_INIT,
      CMD_TAKE,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_TAKE_PART,
      CMD_GROW,
      CMD_SCAN_NEXT,
      CMD_BORROW_READ,
      CMD_BORROW_DONE,
      CMD_OOM,
      CMD_LINK_INIT,
      CMD_LINK_STEP
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       big;
      logic       head_nz;
      logic       full;
      logic       fit;
      logic       grow_ok;
      logic       div_done;
      logic       multi;
      logic       link_last;
      logic       scan_hit;
      logic       scan_last;
   } dp_stat_type;

   function automatic logic [LIST_W-1:0] list_of(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] t;
      t = s - SIZE_W'(1);
      if (s == '0) begin
         return '0;
      end
      return LIST_W'(t >> GRAN_SHIFT);
   endfunction

endpackage

/* src/sfla_ram.sv */
// ----------------------------------------------------------------------------
// sfla_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfla_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/sfla_ctrl.sv */
// ----------------------------------------------------------------------------
// sfla_ctrl: allocator controller
// Sequences each transaction through the free, pop, refill, divide, borrow and link steps that it needs.
// ----------------------------------------------------------------------------
module sfla_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output sfla_pkg::dp_cmd_type dp_cmd,
   input  sfla_pkg::dp_stat_type dp_stat
);

   typedef enum logic [10:0] {
      ST_IDLE        = 11'b00000000001,
      ST_DISPATCH    = 11'b00000000010,
      ST_ALLOC       = 11'b00000000100,
      ST_POP_WAIT    = 11'b00000001000,
      ST_CHECK       = 11'b00000010000,
      ST_DIV         = 11'b00000100000,
      ST_LINK0       = 11'b00001000000,
      ST_LINK        = 11'b00010000000,
      ST_SCAN        = 11'b00100000000,
      ST_BORROW_WAIT = 11'b01000000000,
      ST_RESP        = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      dp_cmd.code = sfla_pkg::CMD_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dp_cmd.code = sfla_pkg::CMD_LOAD;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (dp_stat.op)
               sfla_pkg::OP_ALLOC: state_in = ST_ALLOC;
               sfla_pkg::OP_FREE: begin
                  dp_cmd.code = sfla_pkg::CMD_FREE_NEW;
                  state_in    = ST_RESP;
               end
               sfla_pkg::OP_REALLOC: begin
                  dp_cmd.code = sfla_pkg::CMD_FREE_OLD;
                  state_in    = ST_ALLOC;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_ALLOC: begin
            if (dp_stat.big) begin
               dp_cmd.code = sfla_pkg::CMD_SET_BIG;
               state_in    = ST_RESP;
            end else if (dp_stat.head_nz) begin
               dp_cmd.code = sfla_pkg::CMD_POP_READ;
               state_in    = ST_POP_WAIT;
            end else begin
               dp_cmd.code = sfla_pkg::CMD_REFILL_INIT;
               state_in    = ST_CHECK;
            end
         end
         ST_POP_WAIT: begin
            dp_cmd.code = sfla_pkg::CMD_POP_DONE;
            state_in    = ST_RESP;
         end
         ST_CHECK: begin
            if (dp_stat.full) begin
               dp_cmd.code = sfla_pkg::CMD_TAKE;
               state_in    = ST_LINK0;
            end else if (dp_stat.fit) begin
               dp_cmd.code = sfla_pkg::CMD_DIV_INIT;
               state_in    = ST_DIV;
            end else begin
               dp_cmd.code = sfla_pkg::CMD_GROW;
               state_in    = dp_stat.grow_ok ? ST_CHECK : ST_SCAN;
            end
         end
         ST_DIV: begin
            if (dp_stat.div_done) begin
               dp_cmd.code = sfla_pkg::CMD_TAKE_PART;
               state_in    = ST_LINK0;
            end else begin
               dp_cmd.code = sfla_pkg::CMD_DIV_STEP;
            end
         end
         ST_LINK0: begin
            if (dp_stat.multi) begin
               dp_cmd.code = sfla_pkg::CMD_LINK_INIT;
               state_in    = ST_LINK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_LINK: begin
            dp_cmd.code = sfla_pkg::CMD_LINK_STEP;
            if (dp_stat.link_last) begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            if (dp_stat.scan_hit) begin
               dp_cmd.code = sfla_pkg::CMD_BORROW_READ;
               state_in    = ST_BORROW_WAIT;
            end else if (dp_stat.scan_last) begin
               dp_cmd.code = sfla_pkg::CMD_OOM;
               state_in    = ST_RESP;
            end else begin
               dp_cmd.code = sfla_pkg::CMD_SCAN_NEXT;
            end
         end
         ST_BORROW_WAIT: begin
            dp_cmd.code = sfla_pkg::CMD_BORROW_DONE;
            state_in    = ST_CHECK;
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held for two cycles");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted transaction did not start");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == ST_IDLE)) else $error("controller not idle after reset");

endmodule

/* src/sfla_dp.sv */
// ----------------------------------------------------------------------------
// sfla_dp: allocator datapath
// Holds list heads, pool bounds and counters, and owns the link store.
// ----------------------------------------------------------------------------
module sfla_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sfla_pkg::dp_cmd_type                dp_cmd,
   output sfla_pkg::dp_stat_type               dp_stat,
   input  logic [1:0]                          req_opcode,
   input  logic [sfla_pkg::SIZE_W-1:0]         req_size,
   input  logic [sfla_pkg::SIZE_W-1:0]         req_old_size,
   input  logic [sfla_pkg::SIZE_W-1:0]         req_address,
   input  logic [sfla_pkg::CNT_W-1:0]          refill_count,
   output logic [sfla_pkg::SIZE_W-1:0]         rsp_block_address,
   output logic [1:0]                          rsp_status
);

   localparam int GW = sfla_pkg::GIDX_W;
   localparam int PW = sfla_pkg::POOL_W;
   localparam int LW = sfla_pkg::LIST_W;
   localparam int CW = sfla_pkg::CNT_W;
   localparam int NW = sfla_pkg::N_W;

   logic [GW-1:0] heads_ff [sfla_pkg::LIST_COUNT];
   sfla_pkg::opcode_type op_ff;
   logic [LW-1:0] idx_ff, oidx_ff, scan_ff;
   logic          big_ff, obig_ff;
   logic [GW-1:0] gaddr_ff;
   logic [PW-1:0] begin_ff, limit_ff, top_ff, taken_ff;
   logic [PW-1:0] total_ff, rem_ff, cur_ff;
   logic [NW-1:0] n_ff;
   logic [CW-1:0] cnt_ff, q_ff, k_ff;
   logic [sfla_pkg::SIZE_W-1:0] res_ff;
   sfla_pkg::status_type stat_ff;

   logic [PW-1:0] left_w, n_ext_w, next_cur_w;
   logic [PW:0]   round_w, grow_w, top_sum_w;
   logic [LW-1:0] lidx_w;
   logic [GW-1:0] head_w, scan_head_w;
   logic [CW-1:0] cnt_init_w;
   logic [NW-1:0] n_init_w;

   logic          ram_we;
   logic [GW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

   sfla_ram #(
      .WIDTH(GW),
      .DEPTH(sfla_pkg::STORE_DEPTH)
   ) u_link_store (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      left_w      = limit_ff - begin_ff;
      n_ext_w     = PW'(n_ff);
      next_cur_w  = cur_ff + n_ext_w;
      round_w     = ((PW+1)'(taken_ff >> 4) + (PW+1)'(7)) & ~(PW+1)'(7);
      grow_w      = {total_ff, 1'b0} + round_w;
      top_sum_w   = {1'b0, top_ff} + grow_w;
      lidx_w      = LW'((left_w - PW'(1)) >> sfla_pkg::GRAN_SHIFT);
      head_w      = heads_ff[idx_ff];
      scan_head_w = heads_ff[scan_ff];
      cnt_init_w  = (refill_count == '0) ? CW'(1) : refill_count;
      n_init_w    = NW'({1'b0, idx_ff} + 5'd1) << sfla_pkg::GRAN_SHIFT;

      dp_stat.op        = op_ff;
      dp_stat.big       = big_ff;
      dp_stat.head_nz   = (head_w != '0);
      dp_stat.full      = (left_w >= total_ff);
      dp_stat.fit       = (left_w >= total_ff) || (left_w >= n_ext_w);
      dp_stat.grow_ok   = (top_sum_w <= (PW+1)'(sfla_pkg::ARENA_CAPACITY));
      dp_stat.div_done  = (rem_ff < n_ext_w);
      dp_stat.multi     = (cnt_ff > CW'(1));
      dp_stat.link_last = ({1'b0, k_ff} + 8'd1) >= {1'b0, cnt_ff};
      dp_stat.scan_hit  = (scan_head_w != '0);
      dp_stat.scan_last = (scan_ff == LW'(sfla_pkg::LIST_COUNT - 1));

      ram_we    = 1'b0;
      ram_waddr = gaddr_ff;
      ram_wdata = head_w;
      ram_raddr = head_w;
      case (dp_cmd.code)
         sfla_pkg::CMD_FREE_OLD: begin
            ram_we    = !obig_ff && (gaddr_ff != '0);
            ram_wdata = heads_ff[oidx_ff];
         end
         sfla_pkg::CMD_FREE_NEW: begin
            ram_we = !big_ff && (gaddr_ff != '0);
         end
         sfla_pkg::CMD_GROW: begin
            ram_we    = (left_w != '0);
            ram_waddr = begin_ff[sfla_pkg::GRAN_SHIFT +: GW];
            ram_wdata = heads_ff[lidx_w];
         end
         sfla_pkg::CMD_BORROW_READ: ram_raddr = scan_head_w;
         sfla_pkg::CMD_LINK_STEP: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff[sfla_pkg::GRAN_SHIFT +: GW];
            ram_wdata = dp_stat.link_last ? '0 : next_cur_w[sfla_pkg::GRAN_SHIFT +: GW];
         end
         default: ram_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sfla_pkg::LIST_COUNT; i++) begin
            heads_ff[i] <= '0;
         end
         begin_ff <= '0;
         limit_ff <= '0;
         top_ff   <= '0;
         taken_ff <= '0;
      end else begin
         case (dp_cmd.code)
            sfla_pkg::CMD_LOAD: begin
               op_ff    <= sfla_pkg::opcode_type'(req_opcode);
               idx_ff   <= sfla_pkg::list_of(req_size);
               big_ff   <= (req_size > sfla_pkg::SIZE_W'(sfla_pkg::SMALL_LIMIT));
               oidx_ff  <= sfla_pkg::list_of(req_old_size);
               obig_ff  <= (req_old_size > sfla_pkg::SIZE_W'(sfla_pkg::SMALL_LIMIT));
               gaddr_ff <= req_address[sfla_pkg::GRAN_SHIFT +: GW];
               res_ff   <= '0;
               stat_ff  <= sfla_pkg::STATUS_DONE;
            end
            sfla_pkg::CMD_FREE_OLD: begin
               if (!obig_ff && (gaddr_ff != '0)) begin
                  heads_ff[oidx_ff] <= gaddr_ff;
               end
            end
            sfla_pkg::CMD_FREE_NEW: begin
               if (big_ff) begin
                  stat_ff <= sfla_pkg::STATUS_OVERSIZE;
               end else if (gaddr_ff != '0) begin
                  heads_ff[idx_ff] <= gaddr_ff;
               end
            end
            sfla_pkg::CMD_SET_BIG: stat_ff <= sfla_pkg::STATUS_OVERSIZE;
            sfla_pkg::CMD_POP_DONE: begin
               heads_ff[idx_ff] <= ram_rdata;
               res_ff           <= {head_w, 3'b000};
            end
            sfla_pkg::CMD_REFILL_INIT: begin
               n_ff     <= n_init_w;
               cnt_ff   <= cnt_init_w;
               total_ff <= PW'(n_init_w) * PW'(cnt_init_w);
            end
            sfla_pkg::CMD_TAKE: begin
               res_ff   <= begin_ff[sfla_pkg::SIZE_W-1:0];
               cur_ff   <= begin_ff + n_ext_w;
               begin_ff <= begin_ff + total_ff;
            end
            sfla_pkg::CMD_DIV_INIT: begin
               rem_ff <= left_w;
               q_ff   <= '0;
            end
            sfla_pkg::CMD_DIV_STEP: begin
               rem_ff <= rem_ff - n_ext_w;
               q_ff   <= q_ff + CW'(1);
            end
            sfla_pkg::CMD_TAKE_PART: begin
               res_ff   <= begin_ff[sfla_pkg::SIZE_W-1:0];
               cur_ff   <= begin_ff + n_ext_w;
               begin_ff <= limit_ff - rem_ff;
               cnt_ff   <= q_ff;
            end
            sfla_pkg::CMD_GROW: begin
               if (left_w != '0) begin
                  heads_ff[lidx_w] <= begin_ff[sfla_pkg::GRAN_SHIFT +: GW];
               end
               scan_ff <= idx_ff;
               if (dp_stat.grow_ok) begin
                  begin_ff <= PW'(sfla_pkg::GRANULE) + top_ff;
                  limit_ff <= PW'(top_sum_w + (PW+1)'(sfla_pkg::GRANULE));
                  top_ff   <= PW'(top_sum_w);
                  taken_ff <= PW'({1'b0, taken_ff} + grow_w);
               end else begin
                  begin_ff <= limit_ff;
               end
            end
            sfla_pkg::CMD_SCAN_NEXT: scan_ff <= scan_ff + LW'(1);
            sfla_pkg::CMD_BORROW_DONE: begin
               heads_ff[scan_ff] <= ram_rdata;
               begin_ff <= PW'({scan_head_w, 3'b000});
               limit_ff <= PW'({scan_head_w, 3'b000})
                           + ((PW'(scan_ff) + PW'(1)) << sfla_pkg::GRAN_SHIFT);
            end
            sfla_pkg::CMD_OOM: begin
               begin_ff <= '0;
               limit_ff <= '0;
               res_ff   <= '0;
               stat_ff  <= sfla_pkg::STATUS_NO_MEMORY;
            end
            sfla_pkg::CMD_LINK_INIT: begin
               heads_ff[idx_ff] <= cur_ff[sfla_pkg::GRAN_SHIFT +: GW];
               k_ff             <= CW'(1);
            end
            sfla_pkg::CMD_LINK_STEP: begin
               cur_ff <= next_cur_w;
               k_ff   <= k_ff + CW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_block_address = res_ff;
   assign rsp_status        = stat_ff;

   a_pool_order: assert property (@(posedge clock) disable iff (reset)
      begin_ff <= limit_ff) else $error("pool begin passed pool limit");

endmodule

/* src/segregated_free_list_allocator_unit.sv */
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_unit: small-block pool allocator
// Top level with the register port, controller and datapath.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; opcode, size,
// old_size and address are sampled then. Exactly one result follows, shown
// for one cycle with rsp_valid high; the receiver cannot stall, so the
// result must be captured in that cycle. busy stays high until the result
// cycle ends, so one transaction is in flight at a time.
// A pop from a nonempty list passes through the dispatch, allocate and
// pop-wait states to the result, and the next transaction can be taken
// in the cycle after the result. A refill passes through the check, a
// divide that counts the blocks when the pool only partly covers the batch,
// a grow or a scan of the lists and a borrow, and the walk over the link
// store, one write per cycle, when more than one block is carved.
// The register objects_per_refill lies at byte address 0 and may be written
// only while busy is low. Reset empties all lists and the pool and sets the
// register to 20; no clearing pass runs, so the block is ready at once.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_opcode,
   input  logic [sfla_pkg::SIZE_W-1:0] req_size,
   input  logic [sfla_pkg::SIZE_W-1:0] req_old_size,
   input  logic [sfla_pkg::SIZE_W-1:0] req_address,
   output logic                        rsp_valid,
   output logic [sfla_pkg::SIZE_W-1:0] rsp_block_address,
   output logic [1:0]                  rsp_status,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic [sfla_pkg::CNT_W-1:0] refill_ff;
   sfla_pkg::dp_cmd_type  dp_cmd;
   sfla_pkg::dp_stat_type dp_stat;

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {25'd0, refill_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         refill_ff <= sfla_pkg::CNT_W'(sfla_pkg::REFILL_RESET);
      end else if (psel && penable && pwrite && !paddr[2]) begin
         refill_ff <= pwdata[sfla_pkg::CNT_W-1:0];
      end
   end

   sfla_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .dp_cmd(dp_cmd),
      .dp_stat(dp_stat)
   );

   sfla_dp u_dp (
      .clock(clock),
      .reset(reset),
      .dp_cmd(dp_cmd),
      .dp_stat(dp_stat),
      .req_opcode(req_opcode),
      .req_size(req_size),
      .req_old_size(req_old_size),
      .req_address(req_address),
      .refill_count(refill_ff),
      .rsp_block_address(rsp_block_address),
      .rsp_status(rsp_status)
   );

endmodule

/* tb/sv/tb_segregated_free_list_allocator_unit.sv */
// ----------------------------------------------------------------------------
// tb_segregated_free_list_allocator_unit: self-checking allocator testbench
// Drives directed transactions, then allocate, free, reallocate and no-op transactions in random bursts.
// The refill count register is changed between phases. A scoreboard keeps
// its own copy of the free lists, link store and pool, predicts each result,
// and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module tb_segregated_free_list_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;

   typedef struct {
      logic [15:0]          addr;
      sfla_pkg::status_type status;
   } grant_type;

   class alloc_scoreboard;
      int unsigned refill_count;
      int unsigned heads[sfla_pkg::LIST_COUNT];
      int unsigned links[sfla_pkg::STORE_DEPTH];
      int unsigned pool_lo, pool_hi, arena_used, taken;
      grant_type   pending[$];
      int          mismatches;

      function new();
         refill_count = sfla_pkg::REFILL_RESET;
         foreach (heads[i]) heads[i] = 0;
         pool_lo = 0;
         pool_hi = 0;
         arena_used = 0;
         taken = 0;
         mismatches = 0;
      endfunction

      function int unsigned size_class(int unsigned s);
         return (s == 0) ? 0 : (s + sfla_pkg::GRANULE - 1) / sfla_pkg::GRANULE - 1;
      endfunction

      function void push(int unsigned idx, int unsigned a);
         int unsigned g;
         g = a / sfla_pkg::GRANULE;
         if (idx >= sfla_pkg::LIST_COUNT || g == 0 || g >= sfla_pkg::STORE_DEPTH) return;
         links[g] = heads[idx];
         heads[idx] = g;
      endfunction

      function int unsigned pop(int unsigned idx);
         int unsigned g;
         if (idx >= sfla_pkg::LIST_COUNT) return 0;
         g = heads[idx];
         if (g == 0) return 0;
         heads[idx] = (g < sfla_pkg::STORE_DEPTH) ? links[g] : 0;
         return g * sfla_pkg::GRANULE;
      endfunction

      function int unsigned carve(int unsigned n, ref int unsigned cnt);
         int unsigned total, left, grow, a, r;
         bit found;
         forever begin
            total = n * cnt;
            left = pool_hi - pool_lo;
            if (left >= total || left >= n) begin
               r = pool_lo;
               if (left < total) begin
                  cnt = left / n;
                  total = cnt * n;
               end
               pool_lo += total;
               return r;
            end
            if (left > 0) push(size_class(left), pool_lo);
            pool_lo = pool_hi;
            grow = 2 * total + ((taken >> 4) + sfla_pkg::GRANULE - 1) / sfla_pkg::GRANULE
                   * sfla_pkg::GRANULE;
            if (arena_used + grow <= sfla_pkg::ARENA_CAPACITY) begin
               pool_lo = sfla_pkg::GRANULE + arena_used;
               pool_hi = pool_lo + grow;
               arena_used += grow;
               taken += grow;
            end else begin
               found = 0;
               for (int unsigned i = size_class(n); i < sfla_pkg::LIST_COUNT && !found;
                    i++) begin
                  a = pop(i);
                  if (a != 0) begin
                     pool_lo = a;
                     pool_hi = a + (i + 1) * sfla_pkg::GRANULE;
                     found = 1;
                  end
               end
               if (!found) begin
                  pool_lo = 0;
                  pool_hi = 0;
                  return 0;
               end
            end
         end
      endfunction

      function grant_type allocate(int unsigned s);
         grant_type   res;
         int unsigned idx, n, cnt, base, g, nx;
         idx = size_class(s);
         res.addr = 0;
         res.status = sfla_pkg::STATUS_DONE;
         if (s > sfla_pkg::SMALL_LIMIT || idx >= sfla_pkg::LIST_COUNT) begin
            res.status = sfla_pkg::STATUS_OVERSIZE;
            return res;
         end
         res.addr = pop(idx);
         if (res.addr != 0) return res;
         n = (idx + 1) * sfla_pkg::GRANULE;
         cnt = (refill_count == 0) ? 1 : refill_count;
         base = carve(n, cnt);
         if (base == 0) begin
            res.status = sfla_pkg::STATUS_NO_MEMORY;
            return res;
         end
         if (cnt > 1) begin
            heads[idx] = (base + n) / sfla_pkg::GRANULE;
            for (int unsigned k = 1; k < cnt; k++) begin
               g = (base + k * n) / sfla_pkg::GRANULE;
               nx = (k + 1 < cnt) ? (base + (k + 1) * n) / sfla_pkg::GRANULE : 0;
               if (g < sfla_pkg::STORE_DEPTH) links[g] = nx;
            end
         end
         res.addr = 16'(base);
         return res;
      endfunction

      function sfla_pkg::status_type release_block(int unsigned s, int unsigned a);
         int unsigned idx;
         idx = size_class(s);
         if (s > sfla_pkg::SMALL_LIMIT || idx >= sfla_pkg::LIST_COUNT) begin
            return sfla_pkg::STATUS_OVERSIZE;
         end
         push(idx, a);
         return sfla_pkg::STATUS_DONE;
      endfunction

      function grant_type note_request(sfla_pkg::opcode_type op, int unsigned s,
                                       int unsigned olds, int unsigned a);
         grant_type res;
         sfla_pkg::status_type st;
         res.addr = 0;
         res.status = sfla_pkg::STATUS_DONE;
         case (op)
            sfla_pkg::OP_ALLOC: begin
               res = allocate(s);
            end
            sfla_pkg::OP_FREE: begin
               res.status = release_block(s, a);
            end
            sfla_pkg::OP_REALLOC: begin
               st = release_block(olds, a);
               res = allocate(s);
            end
            default: begin
            end
         endcase
         pending.push_back(res);
         return res;
      endfunction

      function void check_result(logic [15:0] addr, logic [1:0] status);
         grant_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result: address %0d status %0d",
                                           addr, status);
            return;
         end
         want = pending.pop_front();
         if (addr !== want.addr || status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected address %0d status %0d, got address %0d status %0d",
                        want.addr, want.status, addr, status);
         end
      endfunction
   endclass

   logic        clock, reset, start, busy;
   logic [1:0]  req_opcode;
   logic [15:0] req_size, req_old_size, req_address;
   logic        rsp_valid;
   logic [15:0] rsp_block_address;
   logic [1:0]  rsp_status;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   alloc_scoreboard allocs;
   int unsigned     live_addr[$];
   int unsigned     live_size[$];
   int              cycles;

   segregated_free_list_allocator_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_size(req_size), .req_old_size(req_old_size),
      .req_address(req_address), .rsp_valid(rsp_valid),
      .rsp_block_address(rsp_block_address), .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_valid) allocs.check_result(rsp_block_address, rsp_status);
   end

   task automatic send(sfla_pkg::opcode_type op, int unsigned s, int unsigned olds,
                       int unsigned a);
      grant_type   res;
      int unsigned s16, olds16, a16;
      s16 = s & 32'hffff;
      olds16 = olds & 32'hffff;
      a16 = a & 32'hffff;
      req_opcode = op;
      req_size = 16'(s16);
      req_old_size = 16'(olds16);
      req_address = 16'(a16);
      start = 1;
      while (busy) @(negedge clock);
      @(negedge clock);
      res = allocs.note_request(op, s16, olds16, a16);
      if ((op == sfla_pkg::OP_ALLOC || op == sfla_pkg::OP_REALLOC)
          && res.status == sfla_pkg::STATUS_DONE) begin
         live_addr.push_back(res.addr);
         live_size.push_back(s16);
      end
   endtask

   task automatic idle(int n);
      start = 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      idle(1);
      while (allocs.pending.size() != 0 || busy) @(negedge clock);
      idle(80);
   endtask

   task automatic write_refill(int unsigned v);
      drain();
      psel = 1;
      pwrite = 1;
      paddr = 0;
      pwdata = v;
      penable = 0;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
      allocs.refill_count = v & 32'h7f;
   endtask

   task automatic random_item();
      int unsigned k, pick, s, a;
      k = $urandom_range(0, 99);
      if (k < 45 || live_addr.size() == 0) begin
         send(sfla_pkg::OP_ALLOC, $urandom_range(0, 136), $urandom, $urandom);
      end else if (k < 75) begin
         pick = $urandom_range(0, live_addr.size() - 1);
         a = live_addr[pick];
         s = live_size[pick];
         live_addr.delete(pick);
         live_size.delete(pick);
         send(sfla_pkg::OP_FREE, s, $urandom, a);
      end else if (k < 88) begin
         pick = $urandom_range(0, live_addr.size() - 1);
         a = live_addr[pick];
         s = live_size[pick];
         live_addr.delete(pick);
         live_size.delete(pick);
         send(sfla_pkg::OP_REALLOC, $urandom_range(0, 136), s, a);
      end else if (k < 93) begin
         send(sfla_pkg::OP_FREE, $urandom_range(0, 136), $urandom, $urandom);
      end else if (k < 97) begin
         send(sfla_pkg::opcode_type'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
      end else if (k < 99) begin
         send(sfla_pkg::OP_REALLOC, $urandom_range(0, 136), $urandom, $urandom);
      end else begin
         send(sfla_pkg::OP_NONE, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic random_phase(int count);
      int done, burst;
      done = 0;
      while (done < count) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && done < count; i++) begin
            random_item();
            done++;
         end
         if ($urandom_range(0, 3) != 0) idle($urandom_range(0, 15));
      end
   endtask

   initial begin
      allocs = new();
      cycles = 0;
      reset = 1;
      start = 0;
      req_opcode = sfla_pkg::OP_ALLOC;
      req_size = 0;
      req_old_size = 0;
      req_address = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      repeat (5) @(negedge clock);
      reset = 0;

      send(sfla_pkg::OP_ALLOC, 0, 0, 0);
      send(sfla_pkg::OP_ALLOC, 1, 0, 0);
      send(sfla_pkg::OP_ALLOC, 8, 0, 0);
      send(sfla_pkg::OP_ALLOC, 9, 0, 0);
      send(sfla_pkg::OP_ALLOC, 128, 0, 0);
      send(sfla_pkg::OP_ALLOC, 129, 0, 0);
      send(sfla_pkg::OP_ALLOC, 16'hffff, 16'hffff, 16'hffff);
      send(sfla_pkg::OP_FREE, 0, 0, 16'h0010);
      send(sfla_pkg::OP_FREE, 200, 0, 16'h0020);
      send(sfla_pkg::OP_FREE, 8, 0, 0);
      send(sfla_pkg::OP_FREE, 8, 0, 7);
      send(sfla_pkg::OP_FREE, 128, 0, 16'hffff);
      send(sfla_pkg::OP_FREE, 16, 0, 16'h0033);
      send(sfla_pkg::OP_ALLOC, 16, 0, 0);
      send(sfla_pkg::OP_ALLOC, 128, 0, 0);
      send(sfla_pkg::OP_REALLOC, 64, 16'hffff, 16'h0040);
      send(sfla_pkg::OP_REALLOC, 0, 0, 16'h0008);
      send(sfla_pkg::OP_REALLOC, 300, 8, 16'h0100);
      send(sfla_pkg::OP_NONE, 16'hffff, 16'hffff, 16'hffff);
      send(sfla_pkg::OP_FREE, 8, 8, 16'h0008);
      send(sfla_pkg::OP_FREE, 8, 8, 16'h0008);
      send(sfla_pkg::OP_ALLOC, 8, 0, 0);
      send(sfla_pkg::OP_ALLOC, 8, 0, 0);

      write_refill(64);
      random_phase(450);
      write_refill(1);
      random_phase(350);
      write_refill($urandom_range(2, 63));
      random_phase(250);
      write_refill(0);
      random_phase(100);
      write_refill(20);
      random_phase(150);

      drain();
      if (allocs.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
src/sfla_pkg.sv
src/sfla_ram.sv
src/sfla_ctrl.sv
src/sfla_dp.sv
src/segregated_free_list_allocator_unit.sv
tb/sv/tb_segregated_free_list_allocator_unit.sv
